/* rtl/ctcg_pkg.sv */
package ctcg_pkg;

    localparam int MAX_CLASSES = 8192;
    localparam int MAX_RANKS   = 5;
    localparam int MAX_STEPS   = 1024;
    localparam int SCORE_BITS  = 16;

    localparam int WIDE_RANKS  = 5;
    localparam int WIDE_K      = (WIDE_RANKS > MAX_RANKS) ? MAX_RANKS : WIDE_RANKS;

    localparam int CLASS_W = 13;
    localparam int COL_W   = $clog2(MAX_CLASSES + 1);
    localparam int STEP_W  = 10;
    localparam int RANK_W  = 3;

    localparam logic [CLASS_W-1:0]    BLANK_CLASS = '0;
    localparam logic [SCORE_BITS-1:0] SCORE_MIN   = {1'b1, {(SCORE_BITS-1){1'b0}}};
    localparam logic [COL_W-1:0]      COL_LIMIT   = COL_W'(MAX_CLASSES);
    localparam logic [STEP_W-1:0]     STEP_LAST   = STEP_W'(MAX_STEPS - 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIVE_BEST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLLAPSE  = 1'd1;

    typedef struct packed {
        logic [CLASS_W-1:0]    idx;
        logic [SCORE_BITS-1:0] score;
    } cand_t;

    typedef cand_t [MAX_RANKS-1:0] cand_list_t;
    typedef logic  [MAX_RANKS-1:0] rank_mask_t;

    // One staged input request
    typedef struct packed {
        logic [SCORE_BITS-1:0] score;
        logic                  row_end;
        logic                  seq_end;
    } item_t;

endpackage

/* rtl/ctcg_if.sv */
interface ctcg_in_if;
    import ctcg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [SCORE_BITS-1:0] class_score;
    logic                  row_end;
    logic                  sequence_end;

    modport source (output valid, class_score, row_end, sequence_end, input ready);
    modport sink   (input valid, class_score, row_end, sequence_end, output ready);
endinterface

interface ctcg_out_if;
    import ctcg_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [RANK_W-1:0]     rank;
    logic [CLASS_W-1:0]    class_index;
    logic [SCORE_BITS-1:0] best_score;
    logic [STEP_W-1:0]     time_step;
    logic                  last_of_run;

    modport source (output valid, rank, class_index, best_score, time_step, last_of_run,
                    input ready);
    modport sink   (input valid, rank, class_index, best_score, time_step, last_of_run,
                    output ready);
endinterface

/* rtl/ctcg_topk.sv */
module ctcg_topk
    import ctcg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  upd,
    input  logic [SCORE_BITS-1:0] score,
    input  logic                  row_end,
    output cand_list_t            list_ins
);

    cand_list_t        list_reg;
    cand_list_t        list_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    rank_mask_t        ins;
    logic              take;

    assign take = (col_reg < COL_LIMIT);

    // Insert point: first slot that is unfilled or beaten strictly
    always_comb
    begin
        for (int k = 0; k < MAX_RANKS; k++)
        begin
            if (COL_W'(k) < col_reg)
                ins[k] = ($signed(score) > $signed(list_reg[k].score));
            else
                ins[k] = 1'b1;
        end
    end

    // Shift the tail down by one behind the insert point
    always_comb
    begin
        for (int k = 0; k < MAX_RANKS; k++)
        begin
            if (!take || !ins[k])
                list_ins[k] = list_reg[k];
            else if (k == 0)
                list_ins[k] = '{idx: col_reg[CLASS_W-1:0], score: score};
            else if (!ins[k-1])
                list_ins[k] = '{idx: col_reg[CLASS_W-1:0], score: score};
            else
                list_ins[k] = list_reg[k-1];
        end
    end

    always_comb
    begin
        list_next = list_reg;
        col_next  = col_reg;
        if (upd)
        begin
            if (row_end)
            begin
                for (int k = 0; k < MAX_RANKS; k++)
                    list_next[k] = '{idx: BLANK_CLASS, score: SCORE_MIN};
                col_next = '0;
            end
            else
            begin
                list_next = list_ins;
                if (take)
                    col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_RANKS; k++)
                list_reg[k] <= '{idx: BLANK_CLASS, score: SCORE_MIN};
            col_reg <= '0;
        end
        else
        begin
            list_reg <= list_next;
            col_reg  <= col_next;
        end
    end

endmodule

/* rtl/ctcg_emit.sv */
module ctcg_emit
    import ctcg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  cand_list_t          load_list,
    input  rank_mask_t          load_mask,
    input  logic [STEP_W-1:0]   load_step,
    output logic                can_load,
    ctcg_out_if.source          results
);

    cand_list_t         list_reg;
    rank_mask_t         mask_reg;
    rank_mask_t         mask_next;
    logic [STEP_W-1:0]  step_reg;
    rank_mask_t         sel;
    rank_mask_t         rest;

    // Lowest pending rank goes out first
    assign sel      = mask_reg & (~mask_reg + rank_mask_t'(1));
    assign rest     = (results.valid && results.ready) ? (mask_reg & ~sel) : mask_reg;
    assign can_load = (rest == '0);

    always_comb
    begin
        results.rank        = '0;
        results.class_index = list_reg[0].idx;
        results.best_score  = list_reg[0].score;
        for (int k = 0; k < MAX_RANKS; k++)
        begin
            if (sel[k])
            begin
                results.rank        = RANK_W'(k);
                results.class_index = list_reg[k].idx;
                results.best_score  = list_reg[k].score;
            end
        end
    end

    assign results.valid       = (mask_reg != '0);
    assign results.time_step   = step_reg;
    assign results.last_of_run = ((mask_reg & ~sel) == '0);

    assign mask_next = load ? load_mask : rest;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    // Payload of the run being drained
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            list_reg <= load_list;
            step_reg <= load_step;
        end
    end

endmodule

/* rtl/topk_ctc_greedy_decoder.sv */
// Streaming top-K CTC greedy decoder. Class scores (signed Q8.8) arrive one
// request per cycle, class 0 first, row_end on the last class of a time step
// and sequence_end with it on the last step of a sequence. Each request is
// taken into an input register and folded into a sorted list of the five best classes by
// parallel compare-and-shift logic, so one score is accepted every cycle. At a row end the
// nonblank ranks (rank 0 alone without five_best_mode; no repeats of the previous row
// under collapse_repeats) go to a buffer sending one result per cycle while results.ready
// is high, best rank first, last_of_run on the final one of the step. Input stalls only
// when a row end reaches the buffer while the previous row still has results to send, so
// rows of at least as many classes as pending results stream at full rate. The user must
// write five_best_mode and collapse_repeats only while the block is idle; it is not enforced.
module topk_ctc_greedy_decoder
    import ctcg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_wdata,
    ctcg_in_if.sink              scores,
    ctcg_out_if.source           results
);

    logic               five_best_reg;
    logic               collapse_reg;
    logic               stg_valid_reg;
    item_t              stg_reg;
    logic               advance;
    logic               can_load;
    logic               load;
    cand_list_t         list_ins;
    cand_list_t         prev_reg;
    cand_list_t         prev_next;
    logic               have_prev_reg;
    logic               have_prev_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    rank_mask_t         emit_mask;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            five_best_reg <= 1'b0;
            collapse_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIVE_BEST: five_best_reg <= cfg_wdata;
                CFG_COLLAPSE:  collapse_reg  <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // Input register
    assign advance      = stg_valid_reg && (!stg_reg.row_end || can_load);
    assign scores.ready = !stg_valid_reg || advance;
    assign load         = advance && stg_reg.row_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (scores.ready)
            stg_valid_reg <= scores.valid;
    end

    always_ff @(posedge clk)
    begin
        if (scores.valid && scores.ready)
            stg_reg <= '{score: scores.class_score, row_end: scores.row_end,
                         seq_end: scores.sequence_end};
    end

    ctcg_topk u_topk (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (advance),
        .score    (stg_reg.score),
        .row_end  (stg_reg.row_end),
        .list_ins (list_ins)
    );

    // Ranks to report for the finished row
    always_comb
    begin
        for (int k = 0; k < MAX_RANKS; k++)
        begin
            emit_mask[k] = ((k == 0) || (five_best_reg && (k < WIDE_K)))
                        && (list_ins[k].idx != BLANK_CLASS)
                        && !(collapse_reg && have_prev_reg
                             && (prev_reg[k].idx == list_ins[k].idx));
        end
    end

    // Previous row and step count
    always_comb
    begin
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        step_next      = step_reg;
        if (load)
        begin
            if (stg_reg.seq_end)
            begin
                for (int k = 0; k < MAX_RANKS; k++)
                    prev_next[k] = '{idx: BLANK_CLASS, score: SCORE_MIN};
                have_prev_next = 1'b0;
                step_next      = '0;
            end
            else
            begin
                prev_next      = list_ins;
                have_prev_next = 1'b1;
                step_next      = (step_reg == STEP_LAST) ? '0 : step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_RANKS; k++)
                prev_reg[k] <= '{idx: BLANK_CLASS, score: SCORE_MIN};
            have_prev_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            step_reg      <= step_next;
        end
    end

    ctcg_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_list (list_ins),
        .load_mask (emit_mask),
        .load_step (step_reg),
        .can_load  (can_load),
        .results   (results)
    );

    // A blank class is never reported
    a_no_blank: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.class_index != BLANK_CLASS))
        else $error("blank class reported");

    // More results of the same step follow a non-final one
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.last_of_run) |=> results.valid)
        else $error("run ended without last_of_run");

    // Ranks within a step rise
    a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && !results.last_of_run)
        |=> (results.rank > $past(results.rank)))
        else $error("rank order broken");

    // Buffer empties after the last result unless a new row loads
    a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.last_of_run && !load)
        |=> !results.valid)
        else $error("result after last_of_run");

endmodule
